@@ rtl/acpu_pkg.sv @@
// Package for the 8-bit accumulator CPU: widths, opcodes, decode function,
// request modes, controller states, datapath commands and the response record.
// No dependencies.
package acpu_pkg;

  localparam int unsigned MEM_BYTES = 256;
  localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CNT_W     = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [DATA_W-1:0] SIGN_MASK = 8'h80;

  localparam logic [DATA_W-1:0] OP_NOP = 8'h00;
  localparam logic [DATA_W-1:0] OP_STA = 8'h10;
  localparam logic [DATA_W-1:0] OP_LDA = 8'h20;
  localparam logic [DATA_W-1:0] OP_ADD = 8'h30;
  localparam logic [DATA_W-1:0] OP_OR  = 8'h40;
  localparam logic [DATA_W-1:0] OP_AND = 8'h50;
  localparam logic [DATA_W-1:0] OP_NOT = 8'h60;
  localparam logic [DATA_W-1:0] OP_JMP = 8'h80;
  localparam logic [DATA_W-1:0] OP_JN  = 8'h90;
  localparam logic [DATA_W-1:0] OP_JZ  = 8'hA0;
  localparam logic [DATA_W-1:0] OP_HLT = 8'hF0;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_EXEC  = 2'd2,
    MODE_RESET = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OPC_NOP, OPC_STA, OPC_LDA, OPC_ADD, OPC_OR, OPC_AND,
    OPC_NOT, OPC_JMP, OPC_JN, OPC_JZ, OPC_HLT, OPC_BAD
  } opc_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDWAIT, ST_FETCH, ST_OPADDR, ST_OPER, ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    DP_NONE, DP_START, DP_RDCAP, DP_DECODE, DP_OPADDR, DP_OPER, DP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    logic halted;
    opc_e rd_class;
    opc_e ir_class;
  } dp_status_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] acc;
    logic [ADDR_W-1:0] prog_counter;
    logic [DATA_W-1:0] instr;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_data;
    logic              neg_flag;
    logic              zero_flag;
    logic              is_halted;
    logic              still_running;
    logic              bad_opcode;
    logic [CNT_W-1:0]  instr_count;
  } resp_t;

  function automatic opc_e decode_op(input logic [DATA_W-1:0] b);
    opc_e c;
    unique case (b)
      OP_NOP:  c = OPC_NOP;
      OP_STA:  c = OPC_STA;
      OP_LDA:  c = OPC_LDA;
      OP_ADD:  c = OPC_ADD;
      OP_OR:   c = OPC_OR;
      OP_AND:  c = OPC_AND;
      OP_NOT:  c = OPC_NOT;
      OP_JMP:  c = OPC_JMP;
      OP_JN:   c = OPC_JN;
      OP_JZ:   c = OPC_JZ;
      OP_HLT:  c = OPC_HLT;
      default: c = OPC_BAD;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/acpu_if.sv @@
// Request and response channel interfaces of the accumulator CPU.
// Depends on acpu_pkg.
interface acpu_req_if import acpu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;

  modport source (output valid, mode, address, data, input ready);
  modport sink   (input valid, mode, address, data, output ready);
endinterface

interface acpu_rsp_if import acpu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [DATA_W-1:0] acc;
  logic [ADDR_W-1:0] prog_counter;
  logic [DATA_W-1:0] instr;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_data;
  logic              neg_flag;
  logic              zero_flag;
  logic              is_halted;
  logic              still_running;
  logic              bad_opcode;
  logic [CNT_W-1:0]  instr_count;

  modport source (output valid, read_data, acc, prog_counter, instr, mem_addr, mem_data,
                  neg_flag, zero_flag, is_halted, still_running, bad_opcode, instr_count,
                  input ready);
  modport sink   (input valid, read_data, acc, prog_counter, instr, mem_addr, mem_data,
                  neg_flag, zero_flag, is_halted, still_running, bad_opcode, instr_count,
                  output ready);
endinterface

@@ rtl/acpu_ctrl.sv @@
// Controller state machine of the accumulator CPU: sequences request phases
// and owns the response valid flag. Depends on acpu_pkg.
module acpu_ctrl import acpu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  req_mode_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  input  dp_status_t  status_i,
  output dp_op_e      op_o
);

  ctrl_state_e state_q, state_d;
  logic        out_vld_q, out_vld_d;
  logic        load_out;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          unique case (mode_e'(req_mode_i))
            MODE_READ:  state_d = ST_RDWAIT;
            MODE_EXEC:  state_d = status_i.halted ? ST_DONE : ST_FETCH;
            MODE_WRITE: state_d = ST_DONE;
            MODE_RESET: state_d = ST_DONE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_RDWAIT: state_d = ST_DONE;
      ST_FETCH: begin
        unique case (status_i.rd_class)
          OPC_STA, OPC_LDA, OPC_ADD, OPC_OR, OPC_AND,
          OPC_JMP, OPC_JN, OPC_JZ: state_d = ST_OPADDR;
          default:                 state_d = ST_DONE;
        endcase
      end
      ST_OPADDR: begin
        unique case (status_i.ir_class)
          OPC_LDA, OPC_ADD, OPC_OR, OPC_AND: state_d = ST_OPER;
          default:                           state_d = ST_DONE;
        endcase
      end
      ST_OPER: state_d = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    op_o        = DP_NONE;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_o = DP_START;
        end
      end
      ST_RDWAIT: op_o = DP_RDCAP;
      ST_FETCH:  op_o = DP_DECODE;
      ST_OPADDR: op_o = DP_OPADDR;
      ST_OPER:   op_o = DP_OPER;
      ST_DONE: begin
        if (!out_vld_q || rsp_ready_i) begin
          load_out = 1'b1;
          op_o     = DP_LOAD_OUT;
        end
      end
      default: op_o = DP_NONE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign rsp_valid_o = out_vld_q;

endmodule

@@ rtl/acpu_dp.sv @@
// Datapath of the accumulator CPU: 256-byte memory with per-byte valid bits,
// architectural registers and the response register. Depends on acpu_pkg.
module acpu_dp import acpu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_op_e            op_i,
  input  logic [1:0]        mode_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [DATA_W-1:0] data_i,
  output dp_status_t        status_o,
  output resp_t             resp_o
);

  logic [DATA_W-1:0] mem [MEM_BYTES];
  logic [MEM_BYTES-1:0] vld_q;
  logic [DATA_W-1:0] raw_q;
  logic              rvld_q;
  logic [DATA_W-1:0] mem_rdata;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wdata;

  logic [DATA_W-1:0] acc_q, acc_d, ir_q, ir_d, mdr_q, mdr_d, rd_q, rd_d;
  logic [ADDR_W-1:0] pc_q, pc_d, mar_q, mar_d;
  logic              n_q, n_d, z_q, z_d, halt_q, halt_d, run_q, run_d, bad_q, bad_d;
  logic [CNT_W-1:0]  count_q, count_d;
  resp_t             out_q, out_d;
  opc_e              rd_class, ir_class;

  assign mem_rdata = rvld_q ? raw_q : '0;
  assign rd_class  = decode_op(mem_rdata);
  assign ir_class  = decode_op(ir_q);

  always_comb begin
    acc_d = acc_q; ir_d = ir_q; mdr_d = mdr_q; rd_d = rd_q;
    pc_d = pc_q; mar_d = mar_q;
    n_d = n_q; z_d = z_q; halt_d = halt_q; run_d = run_q; bad_d = bad_q;
    count_d = count_q; out_d = out_q;
    mem_we = 1'b0; mem_re = 1'b0; mem_addr = '0; mem_wdata = '0;

    unique case (op_i)
      DP_START: begin
        rd_d  = '0;
        run_d = 1'b0;
        bad_d = 1'b0;
        unique case (mode_e'(mode_i))
          MODE_WRITE: begin
            mem_we    = 1'b1;
            mem_addr  = address_i;
            mem_wdata = data_i;
          end
          MODE_READ: begin
            mem_re   = 1'b1;
            mem_addr = address_i;
          end
          MODE_EXEC: begin
            if (!halt_q) begin
              mar_d    = pc_q;
              pc_d     = pc_q + ADDR_W'(1);
              count_d  = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
              mem_re   = 1'b1;
              mem_addr = pc_q;
            end
          end
          MODE_RESET: begin
            acc_d = '0; pc_d = '0; ir_d = '0; mar_d = '0; mdr_d = '0;
            n_d = 1'b0; z_d = 1'b1; halt_d = 1'b0; count_d = '0;
          end
          default: ;
        endcase
      end
      DP_RDCAP: rd_d = mem_rdata;
      DP_DECODE: begin
        mdr_d = mem_rdata;
        ir_d  = mem_rdata;
        unique case (rd_class)
          OPC_STA, OPC_LDA, OPC_ADD, OPC_OR, OPC_AND,
          OPC_JMP, OPC_JN, OPC_JZ: begin
            mem_re   = 1'b1;
            mem_addr = pc_q;
            pc_d     = pc_q + ADDR_W'(1);
          end
          OPC_NOT: begin
            acc_d = ~acc_q;
            n_d   = |(acc_d & SIGN_MASK);
            z_d   = (acc_d == '0);
            run_d = 1'b1;
          end
          OPC_NOP: run_d = 1'b1;
          OPC_HLT: halt_d = 1'b1;
          default: begin
            halt_d = 1'b1;
            bad_d  = 1'b1;
          end
        endcase
      end
      DP_OPADDR: begin
        mar_d = mem_rdata;
        run_d = 1'b1;
        unique case (ir_class)
          OPC_STA: begin
            mem_we    = 1'b1;
            mem_addr  = mem_rdata;
            mem_wdata = acc_q;
          end
          OPC_JMP: pc_d = mem_rdata;
          OPC_JN:  pc_d = n_q ? mem_rdata : pc_q;
          OPC_JZ:  pc_d = z_q ? mem_rdata : pc_q;
          OPC_LDA, OPC_ADD, OPC_OR, OPC_AND: begin
            mem_re   = 1'b1;
            mem_addr = mem_rdata;
          end
          default: ;
        endcase
      end
      DP_OPER: begin
        mdr_d = mem_rdata;
        unique case (ir_class)
          OPC_LDA: acc_d = mem_rdata;
          OPC_ADD: acc_d = acc_q + mem_rdata;
          OPC_OR:  acc_d = acc_q | mem_rdata;
          OPC_AND: acc_d = acc_q & mem_rdata;
          default: acc_d = acc_q;
        endcase
        n_d   = |(acc_d & SIGN_MASK);
        z_d   = (acc_d == '0);
        run_d = 1'b1;
      end
      DP_LOAD_OUT: begin
        out_d.read_data     = rd_q;
        out_d.acc           = acc_q;
        out_d.prog_counter  = pc_q;
        out_d.instr         = ir_q;
        out_d.mem_addr      = mar_q;
        out_d.mem_data      = mdr_q;
        out_d.neg_flag      = n_q;
        out_d.zero_flag     = z_q;
        out_d.is_halted     = halt_q;
        out_d.still_running = run_q;
        out_d.bad_opcode    = bad_q;
        out_d.instr_count   = count_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      raw_q <= mem[mem_addr];
    end
    out_q <= out_d;
    rd_q  <= rd_d;
    run_q <= run_d;
    bad_q <= bad_d;
  end

  // unwritten bytes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[mem_addr] <= 1'b1;
      end
      if (mem_re) begin
        rvld_q <= vld_q[mem_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      pc_q    <= '0;
      ir_q    <= '0;
      mar_q   <= '0;
      mdr_q   <= '0;
      n_q     <= 1'b0;
      z_q     <= 1'b1;
      halt_q  <= 1'b0;
      count_q <= '0;
    end else begin
      acc_q   <= acc_d;
      pc_q    <= pc_d;
      ir_q    <= ir_d;
      mar_q   <= mar_d;
      mdr_q   <= mdr_d;
      n_q     <= n_d;
      z_q     <= z_d;
      halt_q  <= halt_d;
      count_q <= count_d;
    end
  end

  assign status_o.halted   = halt_q;
  assign status_o.rd_class = rd_class;
  assign status_o.ir_class = ir_class;
  assign resp_o            = out_q;

endmodule

@@ rtl/accumulator_cpu_8bit_core.sv @@
// Top level of the 8-bit accumulator CPU: controller plus datapath.
// Depends on acpu_pkg, acpu_req_if, acpu_rsp_if, acpu_ctrl and acpu_dp.
//
// Usage: each request on req_i carries mode, address and data. Mode write
// stores data at address, mode read returns the byte at address in
// read_data, mode execute runs one full instruction, mode reset clears the
// CPU registers and keeps memory. Every request yields exactly one response
// on rsp_o with the register state after the request.
// Write, reset and execute while halted go straight to the response; read
// and execute of NOP, NOT, HLT or an unknown opcode wait for one memory
// read, STA and jumps for two, LDA, ADD, OR and AND for three. This is set
// by the single-port memory with a registered read: fetch, operand address
// and operand are three dependent reads. One request is in flight at a time;
// the next one is taken once the response is in the output register.
// Reset clears the architectural registers, the response valid flag and the
// memory (per-byte valid bits, so memory reads zero at once; no clearing
// pass). When the receiver stalls, the response holds in the output
// register and a request already in flight waits for it to drain.
module accumulator_cpu_8bit_core import acpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  acpu_req_if.sink   req_i,
  acpu_rsp_if.source rsp_o
);

  dp_op_e     op;
  dp_status_t status;
  resp_t      resp;

  acpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_mode_i  (req_i.mode),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .op_o        (op)
  );

  acpu_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .mode_i    (req_i.mode),
    .address_i (req_i.address),
    .data_i    (req_i.data),
    .status_o  (status),
    .resp_o    (resp)
  );

  assign rsp_o.read_data     = resp.read_data;
  assign rsp_o.acc           = resp.acc;
  assign rsp_o.prog_counter  = resp.prog_counter;
  assign rsp_o.instr         = resp.instr;
  assign rsp_o.mem_addr      = resp.mem_addr;
  assign rsp_o.mem_data      = resp.mem_data;
  assign rsp_o.neg_flag      = resp.neg_flag;
  assign rsp_o.zero_flag     = resp.zero_flag;
  assign rsp_o.is_halted     = resp.is_halted;
  assign rsp_o.still_running = resp.still_running;
  assign rsp_o.bad_opcode    = resp.bad_opcode;
  assign rsp_o.instr_count   = resp.instr_count;

endmodule

@@ rtl/acpu_checker.sv @@
// Port-level checks for the accumulator CPU, bound to its top level.
// Depends on acpu_pkg.
module acpu_checker import acpu_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [DATA_W-1:0] acc_i,
  input logic              neg_flag_i,
  input logic              zero_flag_i,
  input logic              is_halted_i,
  input logic              still_running_i,
  input logic              bad_opcode_i,
  input logic [CNT_W-1:0]  instr_count_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(acc_i) && $stable(instr_count_i))
    else $error("response changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second request taken while one is in flight");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (zero_flag_i == (acc_i == '0)) && (neg_flag_i == acc_i[DATA_W-1]))
    else $error("flags disagree with accumulator");

  a_bad_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && bad_opcode_i |-> is_halted_i && !still_running_i)
    else $error("unknown opcode without halt");

  a_run_not_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && still_running_i |-> !is_halted_i)
    else $error("running step reported while halted");

endmodule

bind accumulator_cpu_8bit_core acpu_checker u_acpu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .acc_i           (rsp_o.acc),
  .neg_flag_i      (rsp_o.neg_flag),
  .zero_flag_i     (rsp_o.zero_flag),
  .is_halted_i     (rsp_o.is_halted),
  .still_running_i (rsp_o.still_running),
  .bad_opcode_i    (rsp_o.bad_opcode),
  .instr_count_i   (rsp_o.instr_count)
);

@@ tb/accumulator_cpu_8bit_core_tb.sv @@
// Testbench for accumulator_cpu_8bit_core: directed program table, then random programs.
// Responses are checked field by field against a cycle-free shadow model of the CPU.
// Depends on acpu_pkg, acpu_req_if, acpu_rsp_if and the core RTL.
module accumulator_cpu_8bit_core_tb;
  import acpu_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int ITEMS_TARGET = 2000;
  localparam int DIR_N        = 35;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic        typed;
    logic [7:0]  rd;
  } step_row_t;

  // typed rows expect the register reset state plus the read byte
  localparam step_row_t DIR_TBL [DIR_N] = '{
    '{MODE_READ,  8'h00, 8'h00, 1'b1, 8'h00},
    '{MODE_WRITE, 8'hFF, 8'hFF, 1'b0, 8'h00},
    '{MODE_READ,  8'hFF, 8'h00, 1'b1, 8'hFF},
    '{MODE_WRITE, 8'h00, OP_LDA, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h01, 8'hFF, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h02, OP_ADD, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h03, 8'hFF, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h04, OP_NOT, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h05, OP_AND, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h06, 8'h00, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h07, OP_JZ, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h08, 8'h0B, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h0B, OP_OR, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h0C, 8'hFF, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h0D, OP_JN, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h0E, 8'hFE, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_WRITE, 8'hFE, OP_STA, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h00, OP_JMP, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_EXEC,  8'hFF, 8'hFF, 1'b0, 8'h00},
    '{MODE_RESET, 8'h00, 8'h00, 1'b1, 8'h00},
    '{MODE_WRITE, 8'h00, OP_NOP, 1'b0, 8'h00},
    '{MODE_WRITE, 8'h01, OP_HLT, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_EXEC,  8'h00, 8'h00, 1'b0, 8'h00},
    '{MODE_RESET, 8'hFF, 8'hFF, 1'b1, 8'h00}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  acpu_req_if req_if ();
  acpu_rsp_if rsp_if ();

  accumulator_cpu_8bit_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // shadow CPU state
  logic [7:0]  sh_mem [MEM_BYTES];
  logic [7:0]  sh_acc, sh_pc, sh_ir, sh_mar, sh_mdr;
  logic        sh_n, sh_z, sh_halt;
  logic [31:0] sh_cnt;

  resp_t rsp_due [$];
  int    errs;
  int    n_items;
  int    n_rsp;
  int    n_run;
  int    n_bad;
  int    cycle_cnt;
  bit    idle_on;
  int    hold_req;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit has_operand(logic [7:0] op);
    return op inside {OP_STA, OP_LDA, OP_ADD, OP_OR, OP_AND, OP_JMP, OP_JN, OP_JZ};
  endfunction

  function automatic void shadow_regs_clear();
    sh_acc = '0;
    sh_pc = '0;
    sh_ir = '0;
    sh_mar = '0;
    sh_mdr = '0;
    sh_n = 1'b0;
    sh_z = 1'b1;
    sh_halt = 1'b0;
    sh_cnt = '0;
  endfunction

  function automatic resp_t step_shadow_cpu(mode_e mode, logic [7:0] addr, logic [7:0] data);
    resp_t r;
    bit    upd;
    r = '0;
    upd = 1'b0;
    case (mode)
      MODE_WRITE: sh_mem[addr] = data;
      MODE_READ:  r.read_data = sh_mem[addr];
      MODE_EXEC: begin
        if (!sh_halt) begin
          sh_mar = sh_pc;
          sh_mdr = sh_mem[sh_mar];
          sh_ir = sh_mdr;
          sh_pc = sh_pc + 8'd1;
          if (sh_cnt != CNT_MAX) sh_cnt = sh_cnt + 32'd1;
          if (has_operand(sh_ir)) begin
            sh_mar = sh_mem[sh_pc];
            sh_pc = sh_pc + 8'd1;
          end
          r.still_running = 1'b1;
          case (sh_ir)
            OP_NOP: ;
            OP_STA: sh_mem[sh_mar] = sh_acc;
            OP_LDA: begin
              sh_mdr = sh_mem[sh_mar];
              sh_acc = sh_mdr;
              upd = 1'b1;
            end
            OP_ADD: begin
              sh_mdr = sh_mem[sh_mar];
              sh_acc = sh_acc + sh_mdr;
              upd = 1'b1;
            end
            OP_OR: begin
              sh_mdr = sh_mem[sh_mar];
              sh_acc = sh_acc | sh_mdr;
              upd = 1'b1;
            end
            OP_AND: begin
              sh_mdr = sh_mem[sh_mar];
              sh_acc = sh_acc & sh_mdr;
              upd = 1'b1;
            end
            OP_NOT: begin
              sh_acc = ~sh_acc;
              upd = 1'b1;
            end
            OP_JMP: sh_pc = sh_mar;
            OP_JN:  if (sh_n) sh_pc = sh_mar;
            OP_JZ:  if (sh_z) sh_pc = sh_mar;
            OP_HLT: begin
              sh_halt = 1'b1;
              r.still_running = 1'b0;
            end
            default: begin
              sh_halt = 1'b1;
              r.still_running = 1'b0;
              r.bad_opcode = 1'b1;
            end
          endcase
          if (upd) begin
            sh_n = (sh_acc & SIGN_MASK) != 8'h00;
            sh_z = (sh_acc == 8'h00);
          end
        end
      end
      default: shadow_regs_clear();
    endcase
    r.acc = sh_acc;
    r.prog_counter = sh_pc;
    r.instr = sh_ir;
    r.mem_addr = sh_mar;
    r.mem_data = sh_mdr;
    r.neg_flag = sh_n;
    r.zero_flag = sh_z;
    r.is_halted = sh_halt;
    r.instr_count = sh_cnt;
    return r;
  endfunction

  task automatic send_req(input mode_e mode, input logic [7:0] addr, input logic [7:0] data,
                          input logic typed = 1'b0, input logic [7:0] typed_rd = 8'h00);
    int    gap;
    resp_t want;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.address <= addr;
    req_if.data <= data;
    do @(posedge clk_i); while (!req_if.ready);
    want = step_shadow_cpu(mode, addr, data);
    if (typed) begin
      want = '0;
      want.read_data = typed_rd;
      want.zero_flag = 1'b1;
    end
    rsp_due.push_back(want);
    n_items++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    wait (rsp_due.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic send_noise();
    send_req(mode_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_opcode();
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 6)  return OP_NOP;
    if (r < 16) return OP_STA;
    if (r < 32) return OP_LDA;
    if (r < 44) return OP_ADD;
    if (r < 52) return OP_OR;
    if (r < 60) return OP_AND;
    if (r < 68) return OP_NOT;
    if (r < 74) return OP_JMP;
    if (r < 82) return OP_JN;
    if (r < 90) return OP_JZ;
    if (r < 95) return OP_HLT;
    do b = 8'($urandom_range(0, 255));
    while (b inside {OP_NOP, OP_STA, OP_LDA, OP_ADD, OP_OR, OP_AND, OP_NOT,
                     OP_JMP, OP_JN, OP_JZ, OP_HLT});
    return b;
  endfunction

  // load a short program at the current PC, jumps mostly landing on its own
  // instruction starts, then step through it with some stray requests mixed in
  task automatic run_program();
    int         n_ins, n_seed, n_steps, i;
    logic [7:0] ops [$];
    logic [7:0] starts [$];
    logic [7:0] at, opnd;
    if (sh_halt || $urandom_range(0, 3) == 0)
      send_req(MODE_RESET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    n_seed = $urandom_range(1, 4);
    for (i = 0; i < n_seed; i++)
      send_req(MODE_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    n_ins = $urandom_range(3, 12);
    at = sh_pc;
    for (i = 0; i < n_ins; i++) begin
      ops.push_back(pick_opcode());
      starts.push_back(at);
      at = at + (has_operand(ops[i]) ? 8'd2 : 8'd1);
    end
    at = sh_pc;
    for (i = 0; i < n_ins; i++) begin
      send_req(MODE_WRITE, at, ops[i]);
      at = at + 8'd1;
      if (has_operand(ops[i])) begin
        if (ops[i] inside {OP_JMP, OP_JN, OP_JZ} && $urandom_range(0, 3) != 0)
          opnd = starts[$urandom_range(0, n_ins - 1)];
        else
          opnd = 8'($urandom_range(0, 255));
        send_req(MODE_WRITE, at, opnd);
        at = at + 8'd1;
      end
      if ($urandom_range(0, 9) == 0) send_noise();
    end
    n_steps = n_ins + $urandom_range(0, 6);
    for (i = 0; i < n_steps; i++) begin
      send_req(MODE_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 11) == 0) send_noise();
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errs++;
      if (errs <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_rsp();
    resp_t want;
    if (rsp_due.size() == 0) begin
      errs++;
      $display("%0t: response with no request outstanding", $time);
    end else begin
      want = rsp_due.pop_front();
      cmp_field("read_data", 32'(want.read_data), 32'(rsp_if.read_data));
      cmp_field("acc", 32'(want.acc), 32'(rsp_if.acc));
      cmp_field("prog_counter", 32'(want.prog_counter), 32'(rsp_if.prog_counter));
      cmp_field("instr", 32'(want.instr), 32'(rsp_if.instr));
      cmp_field("mem_addr", 32'(want.mem_addr), 32'(rsp_if.mem_addr));
      cmp_field("mem_data", 32'(want.mem_data), 32'(rsp_if.mem_data));
      cmp_field("neg_flag", 32'(want.neg_flag), 32'(rsp_if.neg_flag));
      cmp_field("zero_flag", 32'(want.zero_flag), 32'(rsp_if.zero_flag));
      cmp_field("is_halted", 32'(want.is_halted), 32'(rsp_if.is_halted));
      cmp_field("still_running", 32'(want.still_running), 32'(rsp_if.still_running));
      cmp_field("bad_opcode", 32'(want.bad_opcode), 32'(rsp_if.bad_opcode));
      cmp_field("instr_count", want.instr_count, rsp_if.instr_count);
      n_rsp++;
      if (rsp_if.still_running === 1'b1) n_run++;
      if (rsp_if.bad_opcode === 1'b1) n_bad++;
    end
  endtask

  // response side: random back-pressure, plus a long hold when requested
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) check_rsp();
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt,
               rsp_due.size());
      $display("** accumulator_cpu_8bit_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int ep;
    int i;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_WRITE;
    req_if.address = '0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    errs = 0;
    n_items = 0;
    n_rsp = 0;
    n_run = 0;
    n_bad = 0;
    cycle_cnt = 0;
    hold_req = 0;
    idle_on = 1'b1;
    for (i = 0; i < MEM_BYTES; i++) sh_mem[i] = '0;
    shadow_regs_clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_N; i++)
      send_req(DIR_TBL[i].mode, DIR_TBL[i].addr, DIR_TBL[i].data, DIR_TBL[i].typed,
               DIR_TBL[i].rd);
    wait_idle();

    ep = 0;
    while (n_items < ITEMS_TARGET) begin
      idle_on = !(ep >= 40 && ep < 55);
      if (ep == 20) hold_req = 300;
      if (ep == 30) wait_idle();
      run_program();
      ep++;
    end
    req_if.valid <= 1'b0;
    wait (rsp_due.size() == 0);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d requests in %0d programs, %0d responses checked", n_items, ep,
             n_rsp);
    $display("%0d instructions completed, %0d halts on bad opcodes, %0d mismatches", n_run,
             n_bad, errs);
    if (errs == 0) begin
      $display("** accumulator_cpu_8bit_core: PASSED **");
    end else begin
      $display("** accumulator_cpu_8bit_core: FAILED **");
    end
    $finish;
  end

endmodule
